FILE: src/ias_pkg.sv
// Package: shared constants, opcodes, status codes and FSM state type for the IAS step block.
`timescale 1ns / 1ps
package ias_pkg;

    localparam int WordW   = 40;
    localparam int HalfW   = 20;
    localparam int PcW     = 10;
    localparam int OpW     = 8;
    localparam int StatW   = 3;
    localparam int MEM_DEPTH_DEF = 1024;
    localparam int AddrLimitMax  = 1024;

    localparam logic [OpW-1:0] OP_LOAD    = 8'h01;
    localparam logic [OpW-1:0] OP_LOAD_NEG = 8'h02;
    localparam logic [OpW-1:0] OP_LOADA   = 8'h03;
    localparam logic [OpW-1:0] OP_ADD     = 8'h05;
    localparam logic [OpW-1:0] OP_SUB     = 8'h06;
    localparam logic [OpW-1:0] OP_ADDA    = 8'h07;
    localparam logic [OpW-1:0] OP_SUBA    = 8'h08;
    localparam logic [OpW-1:0] OP_LDMQM   = 8'h09;
    localparam logic [OpW-1:0] OP_LDMQ    = 8'h0A;
    localparam logic [OpW-1:0] OP_MUL     = 8'h0B;
    localparam logic [OpW-1:0] OP_DIV     = 8'h0C;
    localparam logic [OpW-1:0] OP_JMPL    = 8'h0D;
    localparam logic [OpW-1:0] OP_JMPR    = 8'h0E;
    localparam logic [OpW-1:0] OP_JPL     = 8'h0F;
    localparam logic [OpW-1:0] OP_JPR     = 8'h10;
    localparam logic [OpW-1:0] OP_STORE_LEFT  = 8'h12;
    localparam logic [OpW-1:0] OP_STORE_RIGHT = 8'h13;
    localparam logic [OpW-1:0] OP_LSH     = 8'h14;
    localparam logic [OpW-1:0] OP_RSH     = 8'h15;
    localparam logic [OpW-1:0] OP_STOR    = 8'h21;

    localparam logic [StatW-1:0] ST_OK      = 3'd0;
    localparam logic [StatW-1:0] ST_BADADDR = 3'd1;
    localparam logic [StatW-1:0] ST_DIVZERO = 3'd2;
    localparam logic [StatW-1:0] ST_BADOP   = 3'd3;
    localparam logic [StatW-1:0] ST_PCOVF   = 3'd4;
    localparam logic [StatW-1:0] ST_HALTED  = 3'd5;

    localparam logic [WordW-1:0] MASK_LEFT_ADDR  = 40'hFF000FFFFF;
    localparam logic [WordW-1:0] MASK_RIGHT_ADDR = 40'hFFFFFFF000;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_FETCH,
        S_FWAIT,
        S_OPRD,
        S_OWAIT,
        S_EXEC,
        S_MUL,
        S_DIV,
        S_FINISH,
        S_OUT
    } state_t;

    function automatic logic [WordW-1:0] mag40(input logic [WordW-1:0] x);
        mag40 = x[WordW-1] ? (~x + 1'b1) : x;
    endfunction

endpackage

FILE: src/ias_instruction_step.sv
// Top level: IAS-style 40-bit machine executing one half-instruction per step item.
`timescale 1ns / 1ps
// One item is a load command (write a memory word) or a step command (run one
// 20-bit half-instruction). After reset the block sweeps the word memory to zero,
// one word per cycle, and accepts no item until done. A load result is valid
// once the block has moved to its output state and set its valid register. A
// step result passes through fetch, fetch wait, operand read, operand wait,
// execute and output; MUL and DIV add 40 one-bit iterations of shift-and-add /
// restoring divide plus a finishing step before output. The input is ready
// again in the cycle after the result is taken; no item is accepted before.
// The single memory port (one access per cycle) sets the fetch/operand/writeback
// sequence. Errors halt the block until reset; every later item answers status 5.
module ias_instruction_step
    import ias_pkg::*;
#(
    parameter int MEM_DEPTH = MEM_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_command,
    input  logic [PcW-1:0]      s_load_address,
    input  logic [WordW-1:0]    s_load_word,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [StatW-1:0]    m_status,
    output logic [WordW-1:0]    m_accumulator,
    output logic [WordW-1:0]    m_quotient_register,
    output logic [PcW-1:0]      m_program_counter,
    output logic                m_next_half,
    output logic [OpW-1:0]      m_executed_opcode,
    output logic                m_halted
);
    localparam int AW = $clog2(MEM_DEPTH);
    localparam int Limit = (MEM_DEPTH < AddrLimitMax) ? MEM_DEPTH : AddrLimitMax;
    localparam int CW = 6;

    state_t state_reg, state_next;

    logic [WordW-1:0] acc_reg, acc_next, mq_reg, mq_next;
    logic [PcW-1:0]   pc_reg, pc_next;
    logic             half_reg, half_next, halt_reg, halt_next;
    logic [AW-1:0]    clr_reg, clr_next;
    logic [HalfW-1:0] inst_reg, inst_next;
    logic [WordW-1:0] m_reg, m_next;
    // Serial datapath: hi holds the high part (product or remainder), sh the shifting operand
    logic [WordW-1:0] hi_reg, hi_next, sh_reg, sh_next, d_reg, d_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [StatW-1:0] ostat_reg, ostat_next;
    logic [OpW-1:0]   oop_reg, oop_next;
    logic             mval_reg, mval_next;

    // RAM port
    logic             ram_we;
    logic [AW-1:0]    ram_addr;
    logic [WordW-1:0] ram_wdata, ram_rdata;

    ias_ram #(.Width(WordW), .Depth(MEM_DEPTH)) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    // Decode of held instruction
    logic [OpW-1:0] opc;
    logic [11:0]    iaddr;
    logic           iaddr_ok, pc1_ok, ac_pos;
    logic [PcW:0]   pc_inc;
    assign opc      = inst_reg[HalfW-1:12];
    assign iaddr    = inst_reg[11:0];
    assign iaddr_ok = ({20'd0, iaddr} < 32'(Limit));
    assign pc_inc   = {1'b0, pc_reg} + 1'b1;
    assign pc1_ok   = ({21'd0, pc_inc} < 32'(Limit));
    assign ac_pos   = ~acc_reg[WordW-1];

    logic [AW-1:0] addr_of_i, addr_of_pc, addr_of_ld;
    assign addr_of_i  = AW'(iaddr);
    assign addr_of_pc = AW'(pc_reg);
    assign addr_of_ld = AW'(s_load_address);

    // Serial step arithmetic
    logic [WordW:0] mul_sum;
    logic [WordW:0] div_trial;
    assign mul_sum   = {1'b0, hi_reg} + (sh_reg[0] ? {1'b0, m_reg} : '0);
    assign div_trial = {hi_reg, sh_reg[WordW-1]} - {1'b0, d_reg};

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = mval_reg;
    assign m_status = ostat_reg;
    assign m_accumulator = acc_reg;
    assign m_quotient_register = mq_reg;
    assign m_program_counter = pc_reg;
    assign m_next_half = half_reg;
    assign m_executed_opcode = oop_reg;
    assign m_halted = halt_reg;

    // Registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            acc_reg   <= '0;
            mq_reg    <= '0;
            pc_reg    <= '0;
            half_reg  <= 1'b0;
            halt_reg  <= 1'b0;
            clr_reg   <= '0;
            mval_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
            mq_reg    <= mq_next;
            pc_reg    <= pc_next;
            half_reg  <= half_next;
            halt_reg  <= halt_next;
            clr_reg   <= clr_next;
            mval_reg  <= mval_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        inst_reg  <= inst_next;
        m_reg     <= m_next;
        hi_reg    <= hi_next;
        sh_reg    <= sh_next;
        d_reg     <= d_next;
        ostat_reg <= ostat_next;
        oop_reg   <= oop_next;
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: if (clr_reg == AW'(MEM_DEPTH - 1)) state_next = S_IDLE;
            S_IDLE: begin
                if (s_valid) begin
                    if (halt_reg || !s_command) state_next = S_OUT;
                    else state_next = S_FETCH;
                end
            end
            S_FETCH:  state_next = S_FWAIT;
            S_FWAIT:  state_next = S_OPRD;
            S_OPRD:   state_next = S_OWAIT;
            S_OWAIT:  state_next = S_EXEC;
            S_EXEC: begin
                if (opc == OP_MUL && iaddr_ok) state_next = S_MUL;
                else if (opc == OP_DIV && iaddr_ok && m_reg != '0) state_next = S_DIV;
                else state_next = S_OUT;
            end
            S_MUL:    if (cnt_reg == CW'(WordW - 1)) state_next = S_FINISH;
            S_DIV:    if (cnt_reg == CW'(WordW - 1)) state_next = S_FINISH;
            S_FINISH: state_next = S_OUT;
            S_OUT:    if (mval_reg && m_ready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        logic [WordW-1:0] ac, mq, magm;
        logic [StatW-1:0] st;
        logic             jump, thalf, need;
        acc_next = acc_reg;  mq_next = mq_reg;  pc_next = pc_reg;
        half_next = half_reg; halt_next = halt_reg; clr_next = clr_reg;
        inst_next = inst_reg; m_next = m_reg; hi_next = hi_reg; sh_next = sh_reg;
        d_next = d_reg; cnt_next = cnt_reg; ostat_next = ostat_reg; oop_next = oop_reg;
        mval_next = mval_reg;
        ram_we = 1'b0; ram_addr = addr_of_pc; ram_wdata = '0;
        ac = acc_reg; mq = mq_reg; magm = mag40(m_reg);
        st = ST_OK; jump = 1'b0; thalf = 1'b0; need = 1'b1;
        unique case (state_reg)
            S_CLEAR: begin
                ram_we = 1'b1; ram_addr = clr_reg;
                clr_next = clr_reg + 1'b1;
            end
            S_IDLE: begin
                if (s_valid) begin
                    oop_next = '0;
                    if (halt_reg) begin
                        ostat_next = ST_HALTED;
                    end else if (!s_command) begin
                        if ({22'd0, s_load_address} < 32'(Limit)) begin
                            ram_we = 1'b1; ram_addr = addr_of_ld; ram_wdata = s_load_word;
                            ostat_next = ST_OK;
                        end else begin
                            ostat_next = ST_BADADDR; halt_next = 1'b1;
                        end
                    end
                end
            end
            S_FETCH: ram_addr = addr_of_pc;
            S_FWAIT: inst_next = half_reg ? ram_rdata[HalfW-1:0] : ram_rdata[WordW-1:HalfW];
            S_OPRD:  ram_addr = addr_of_i;
            S_OWAIT: m_next = iaddr_ok ? ram_rdata : '0;
            S_EXEC: begin
                oop_next = opc;
                hi_next = '0; sh_next = mq_reg; cnt_next = '0;
                if (opc == OP_DIV) begin
                    sh_next = mag40(acc_reg); d_next = magm;
                end
                ram_addr = addr_of_i;
                case (opc) inside
                    OP_LOAD:  ac = m_reg;
                    OP_LOAD_NEG: ac = ~m_reg + 1'b1;
                    OP_LOADA: ac = magm;
                    OP_ADD:   ac = acc_reg + m_reg;
                    OP_SUB:   ac = acc_reg - m_reg;
                    OP_ADDA:  ac = acc_reg + magm;
                    OP_SUBA:  ac = acc_reg - magm;
                    OP_LDMQM: mq = m_reg;
                    OP_LDMQ:  ac = mq_reg;
                    OP_MUL:   ;
                    OP_DIV:   if (iaddr_ok && m_reg == '0) st = ST_DIVZERO;
                    OP_JMPL:  jump = 1'b1;
                    OP_JMPR:  begin jump = 1'b1; thalf = 1'b1; end
                    OP_JPL, OP_JPR: begin
                        if (ac_pos) begin jump = 1'b1; thalf = (opc == OP_JPR); end
                        else need = 1'b0;
                    end
                    OP_STORE_LEFT, OP_STORE_RIGHT, OP_STOR: ;
                    OP_LSH:   begin ac = {acc_reg[WordW-2:0], 1'b0}; need = 1'b0; end
                    OP_RSH:   begin ac = {1'b0, acc_reg[WordW-1:1]}; need = 1'b0; end
                    default:  begin st = ST_BADOP; need = 1'b0; end
                endcase
                if (st == ST_OK && need && !iaddr_ok) st = ST_BADADDR;
                if (st != ST_OK) begin
                    halt_next = 1'b1; ostat_next = st;
                end else if (!((opc == OP_MUL || opc == OP_DIV))) begin
                    if (opc == OP_STOR) begin
                        ram_we = 1'b1; ram_wdata = ac;
                    end else if (opc == OP_STORE_LEFT) begin
                        ram_we = 1'b1;
                        ram_wdata = (m_reg & MASK_LEFT_ADDR) | {8'd0, ac[11:0], 20'd0};
                    end else if (opc == OP_STORE_RIGHT) begin
                        ram_we = 1'b1;
                        ram_wdata = (m_reg & MASK_RIGHT_ADDR) | {28'd0, ac[11:0]};
                    end
                    acc_next = ac; mq_next = mq; ostat_next = ST_OK;
                    if (jump) begin
                        pc_next = PcW'(iaddr); half_next = thalf;
                    end else if (!half_reg) begin
                        half_next = 1'b1;
                    end else if (pc1_ok) begin
                        pc_next = pc_inc[PcW-1:0]; half_next = 1'b0;
                    end else begin
                        ostat_next = ST_PCOVF; halt_next = 1'b1;
                    end
                end
            end
            S_MUL: begin
                // shift-and-add, LSB of multiplier first
                hi_next = mul_sum[WordW:1];
                sh_next = {mul_sum[0], sh_reg[WordW-1:1]};
                cnt_next = cnt_reg + 1'b1;
            end
            S_DIV: begin
                // restoring divide, one quotient bit per cycle
                if (!div_trial[WordW]) hi_next = div_trial[WordW-1:0];
                else hi_next = {hi_reg[WordW-2:0], sh_reg[WordW-1]};
                sh_next = {sh_reg[WordW-2:0], ~div_trial[WordW]};
                cnt_next = cnt_reg + 1'b1;
            end
            S_FINISH: begin
                if (opc == OP_MUL) begin
                    acc_next = hi_reg; mq_next = sh_reg;
                end else begin
                    acc_next = hi_reg; mq_next = sh_reg;
                end
                ostat_next = ST_OK;
                if (!half_reg) begin
                    half_next = 1'b1;
                end else if (pc1_ok) begin
                    pc_next = pc_inc[PcW-1:0]; half_next = 1'b0;
                end else begin
                    ostat_next = ST_PCOVF; halt_next = 1'b1;
                end
            end
            S_OUT: begin
                if (!mval_reg) mval_next = 1'b1;
                else if (m_ready) mval_next = 1'b0;
            end
            default: ;
        endcase
    end
endmodule

FILE: src/ias_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module ias_ram #(
    parameter int Width = 40,
    parameter int Depth = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

FILE: bench/ias_instruction_step_test.sv
// Testbench for ias_instruction_step: random programs with a scoreboard-based predictor.
`timescale 1ns / 1ps
module ias_instruction_step_test;
    import ias_pkg::*;

    // opcode that decodes to nothing
    localparam logic [OpW-1:0] OP_UNUSED = 8'hFF;

    typedef struct packed {
        logic [StatW-1:0] status;
        logic [WordW-1:0] acc;
        logic [WordW-1:0] mq;
        logic [PcW-1:0]   pc;
        logic             half;
        logic [OpW-1:0]   opcode;
        logic             halted;
    } step_result_t;

    // machine model: mirrors the word store and registers, queues expected items
    class ias_step_predictor;
        logic [WordW-1:0] words [1024];
        logic [WordW-1:0] acc, mq;
        logic [PcW-1:0]   pc;
        logic             half, halt;
        step_result_t     expected_results[$];
        int               mismatches;

        function new();
            foreach (words[i]) words[i] = '0;
            acc = '0; mq = '0; pc = '0; half = 1'b0; halt = 1'b0;
            mismatches = 0;
        endfunction

        function logic [WordW-1:0] magnitude(logic [WordW-1:0] x);
            return x[WordW-1] ? -x : x;
        endfunction

        // true when stepping the current half-instruction cannot halt the machine
        function bit step_is_safe();
            logic [HalfW-1:0] inst;
            logic [OpW-1:0]   op;
            logic [11:0]      a;
            bit               need, jumps;
            inst = half ? words[pc][19:0] : words[pc][39:20];
            op = inst[19:12];
            a = inst[11:0];
            need = 1; jumps = 0;
            case (op)
                OP_LSH, OP_RSH: need = 0;
                OP_JMPL, OP_JMPR: jumps = 1;
                OP_JPL, OP_JPR: begin
                    jumps = !acc[WordW-1];
                    need = jumps;
                end
                OP_DIV: if (a < 1024 && words[a[9:0]] == 0) return 0;
                OP_LOAD, OP_LOAD_NEG, OP_LOADA, OP_ADD, OP_SUB, OP_ADDA, OP_SUBA,
                OP_LDMQM, OP_LDMQ, OP_MUL, OP_STORE_LEFT, OP_STORE_RIGHT, OP_STOR: ;
                default: return 0;
            endcase
            if (need && a >= 1024) return 0;
            if (!jumps && half && pc == 10'd1023) return 0;
            return 1;
        endfunction

        // apply one accepted item and queue the result it should produce
        function void note_item(logic cmd, logic [PcW-1:0] la, logic [WordW-1:0] lw);
            step_result_t     r;
            logic [HalfW-1:0] inst;
            logic [11:0]      a;
            logic [WordW-1:0] m, ac, nq, d, n;
            logic [79:0]      prod;
            logic [StatW-1:0] st;
            logic [OpW-1:0]   op;
            bit               ok, jump, need;
            logic             th;
            st = ST_OK; op = '0;
            if (halt) begin
                st = ST_HALTED;
            end else if (!cmd) begin
                words[la] = lw;
            end else begin
                inst = half ? words[pc][19:0] : words[pc][39:20];
                a = inst[11:0];
                ok = a < 1024;
                m = ok ? words[a[9:0]] : '0;
                ac = acc; nq = mq;
                jump = 0; th = 1'b0; need = 1;
                op = inst[19:12];
                case (op)
                    OP_LOAD:  ac = m;
                    OP_LOAD_NEG: ac = -m;
                    OP_LOADA: ac = magnitude(m);
                    OP_ADD:   ac = ac + m;
                    OP_SUB:   ac = ac - m;
                    OP_ADDA:  ac = ac + magnitude(m);
                    OP_SUBA:  ac = ac - magnitude(m);
                    OP_LDMQM: nq = m;
                    OP_LDMQ:  ac = nq;
                    OP_MUL: begin
                        prod = {40'b0, nq} * {40'b0, m};
                        ac = prod[79:40];
                        nq = prod[39:0];
                    end
                    OP_DIV: begin
                        if (ok && m == 0) begin
                            st = ST_DIVZERO;
                        end else if (ok) begin
                            d = magnitude(m);
                            n = magnitude(ac);
                            nq = n / d;
                            ac = n % d;
                        end
                    end
                    OP_JMPL: jump = 1;
                    OP_JMPR: begin jump = 1; th = 1'b1; end
                    OP_JPL, OP_JPR: begin
                        if (!ac[WordW-1]) begin
                            jump = 1;
                            th = (op == OP_JPR);
                        end else begin
                            need = 0;
                        end
                    end
                    OP_STORE_LEFT, OP_STORE_RIGHT, OP_STOR: ;
                    OP_LSH: begin ac = ac << 1; need = 0; end
                    OP_RSH: begin ac = ac >> 1; need = 0; end
                    default: begin st = ST_BADOP; need = 0; end
                endcase
                if (st == ST_OK && need && !ok) st = ST_BADADDR;
                if (st != ST_OK) begin
                    halt = 1'b1;
                end else begin
                    if (op == OP_STOR)
                        words[a[9:0]] = ac;
                    else if (op == OP_STORE_LEFT)
                        words[a[9:0]] = (words[a[9:0]] & MASK_LEFT_ADDR) |
                            ({28'b0, ac[11:0]} << 20);
                    else if (op == OP_STORE_RIGHT)
                        words[a[9:0]] = (words[a[9:0]] & MASK_RIGHT_ADDR) | {28'b0, ac[11:0]};
                    acc = ac;
                    mq = nq;
                    if (jump) begin
                        pc = a[9:0];
                        half = th;
                    end else if (!half) begin
                        half = 1'b1;
                    end else if (pc != 10'd1023) begin
                        pc = pc + 1'b1;
                        half = 1'b0;
                    end else begin
                        st = ST_PCOVF;
                        halt = 1'b1;
                    end
                end
            end
            r.status = st; r.acc = acc; r.mq = mq; r.pc = pc;
            r.half = half; r.opcode = op; r.halted = halt;
            expected_results.push_back(r);
        endfunction

        task report(string what, logic [WordW-1:0] got, logic [WordW-1:0] want);
            $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
            mismatches++;
        endtask

        task check_result(step_result_t got);
            step_result_t want;
            if (expected_results.size() == 0) begin
                report("unexpected item", '0, '0);
                return;
            end
            want = expected_results.pop_front();
            if (got.status !== want.status)
                report("status", WordW'(got.status), WordW'(want.status));
            if (got.acc !== want.acc) report("accumulator", got.acc, want.acc);
            if (got.mq !== want.mq) report("quotient_register", got.mq, want.mq);
            if (got.pc !== want.pc)
                report("program_counter", WordW'(got.pc), WordW'(want.pc));
            if (got.half !== want.half)
                report("next_half", WordW'(got.half), WordW'(want.half));
            if (got.opcode !== want.opcode)
                report("executed_opcode", WordW'(got.opcode), WordW'(want.opcode));
            if (got.halted !== want.halted)
                report("halted", WordW'(got.halted), WordW'(want.halted));
        endtask
    endclass

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic               s_command;
    logic [PcW-1:0]     s_load_address;
    logic [WordW-1:0]   s_load_word;
    logic               m_valid;
    logic               m_ready;
    logic [StatW-1:0]   m_status;
    logic [WordW-1:0]   m_accumulator;
    logic [WordW-1:0]   m_quotient_register;
    logic [PcW-1:0]     m_program_counter;
    logic               m_next_half;
    logic [OpW-1:0]     m_executed_opcode;
    logic               m_halted;

    ias_step_predictor machine;
    int                send_idle_pct;
    int                recv_idle_pct;
    int                items_sent;

    logic [OpW-1:0] legal_ops [20] = '{OP_LOAD, OP_LOAD_NEG, OP_LOADA, OP_ADD, OP_SUB,
        OP_ADDA, OP_SUBA, OP_LDMQM, OP_LDMQ, OP_MUL, OP_DIV, OP_JMPL, OP_JMPR, OP_JPL,
        OP_JPR, OP_STORE_LEFT, OP_STORE_RIGHT, OP_LSH, OP_RSH, OP_STOR};

    ias_instruction_step DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_command(s_command),
        .s_load_address(s_load_address), .s_load_word(s_load_word),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_accumulator(m_accumulator), .m_quotient_register(m_quotient_register),
        .m_program_counter(m_program_counter), .m_next_half(m_next_half),
        .m_executed_opcode(m_executed_opcode), .m_halted(m_halted)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // result side: random stalls, check at the rising edge
    always @(negedge aclk) begin
        if (aresetn) m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            machine.check_result('{m_status, m_accumulator, m_quotient_register,
                m_program_counter, m_next_half, m_executed_opcode, m_halted});
    end

    // present one item, hold it until accepted
    task send_item(logic cmd, logic [PcW-1:0] la, logic [WordW-1:0] lw);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_command <= cmd;
        s_load_address <= la;
        s_load_word <= lw;
        do @(posedge aclk); while (!s_ready);
        machine.note_item(cmd, la, lw);
        items_sent++;
    endtask

    function logic [WordW-1:0] rand_word();
        return {8'($urandom_range(0, 255)), $urandom()};
    endfunction

    // write the given half-instruction at the current PC, then execute it
    task run_instruction(logic [OpW-1:0] op, logic [11:0] a);
        logic [WordW-1:0] w;
        if (!machine.half)
            w = {op, a, OP_LSH, 12'($urandom_range(0, 4095))};
        else
            w = {machine.words[machine.pc][39:20], op, a};
        send_item(1'b0, machine.pc, w);
        send_item(1'b1, 10'($urandom()), rand_word());
    endtask

    task random_data_load();
        logic [WordW-1:0] w;
        case ($urandom_range(0, 5))
            0: w = '0;
            1: w = '1;
            2: w = 40'h80_0000_0000;
            3: w = 40'h7F_FFFF_FFFF;
            4: w = 40'($urandom_range(0, 9));
            default: w = rand_word();
        endcase
        send_item(1'b0, 10'($urandom_range(0, 1023)), w);
    endtask

    // a random instruction that cannot stop the machine
    task random_instruction();
        logic [OpW-1:0] op;
        logic [11:0]    a;
        op = legal_ops[$urandom_range(0, 19)];
        a = 12'($urandom_range(0, 1023));
        if (op == OP_LSH || op == OP_RSH) a = 12'($urandom_range(0, 4095));
        if ((op == OP_JPL || op == OP_JPR) && machine.acc[WordW-1])
            a = 12'($urandom_range(0, 4095));
        if (op == OP_DIV && a[9:0] != machine.pc && machine.words[a[9:0]] == 0) op = OP_ADD;
        if (machine.half && machine.pc == 10'd1023) begin
            op = OP_JMPL;
            a = 12'($urandom_range(0, 1023));
        end
        run_instruction(op, a);
    endtask

    // stopping condition, one per run
    task halt_machine();
        logic [PcW-1:0] zero_at;
        case ($urandom_range(0, 3))
            0: run_instruction(OP_LOAD, 12'hC00);
            1: begin
                zero_at = (machine.pc == 10'd1010) ? 10'd1011 : 10'd1010;
                send_item(1'b0, zero_at, '0);
                run_instruction(OP_DIV, {2'b0, zero_at});
            end
            2: run_instruction(OP_UNUSED, 12'h000);
            default: begin
                run_instruction(OP_JMPR, 12'd1023);
                run_instruction(OP_RSH, 12'h000);
            end
        endcase
    endtask

    initial begin
        int     wait_cycles;
        machine = new();
        aclk = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_command = 1'b0;
        s_load_address = '0;
        s_load_word = '0;
        m_ready = 1'b0;
        items_sent = 0;
        send_idle_pct = 37;
        recv_idle_pct = 61;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: operand extremes, then every opcode once
        send_item(1'b0, 10'd1000, '1);
        send_item(1'b0, 10'd1001, 40'h80_0000_0000);
        send_item(1'b0, 10'd1002, 40'h7F_FFFF_FFFF);
        send_item(1'b0, 10'd1003, 40'd3);
        send_item(1'b0, 10'd0, '0);
        run_instruction(OP_LOAD, 12'd1001);
        run_instruction(OP_LOAD_NEG, 12'd1002);
        run_instruction(OP_LOADA, 12'd1000);
        run_instruction(OP_ADD, 12'd1002);
        run_instruction(OP_SUB, 12'd1000);
        run_instruction(OP_ADDA, 12'd1001);
        run_instruction(OP_SUBA, 12'd1000);
        run_instruction(OP_LDMQM, 12'd1000);
        run_instruction(OP_LDMQ, 12'd0);
        run_instruction(OP_MUL, 12'd1000);
        run_instruction(OP_DIV, 12'd1003);
        run_instruction(OP_JPL, 12'd200);
        run_instruction(OP_LSH, 12'hFFF);
        run_instruction(OP_RSH, 12'd0);
        run_instruction(OP_STOR, 12'd1004);
        run_instruction(OP_STORE_LEFT, 12'd1005);
        run_instruction(OP_STORE_RIGHT, 12'd1005);
        run_instruction(OP_JPR, 12'd300);
        run_instruction(OP_JMPL, 12'd100);
        run_instruction(OP_JMPR, 12'd1023);

        // hold off until the block has drained
        @(negedge aclk);
        s_valid <= 1'b0;
        while (machine.expected_results.size() != 0) @(posedge aclk);

        // random programs over three idling phases
        while (items_sent < 1850) begin
            if (items_sent >= 1250) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else if (items_sent >= 650) begin
                send_idle_pct = 61;
                recv_idle_pct = 37;
            end
            case ($urandom_range(0, 9))
                0, 1, 2: random_data_load();
                3, 4, 5: random_instruction();
                default: begin
                    if (machine.step_is_safe())
                        send_item(1'b1, 10'($urandom()), rand_word());
                    else
                        random_instruction();
                end
            endcase
        end

        // stop the machine, then show that it stays stopped
        halt_machine();
        random_data_load();
        send_item(1'b1, 10'($urandom()), rand_word());
        @(negedge aclk);
        s_valid <= 1'b0;

        wait_cycles = 0;
        while (machine.expected_results.size() != 0 && wait_cycles < 200000) begin
            @(posedge aclk);
            wait_cycles++;
        end
        repeat (60) @(posedge aclk);
        if (machine.mismatches == 0 && machine.expected_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // watchdog
    initial begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
